>>> rtl/core/biu_pkg.sv
// shared constants, types and state encoding for the bilinear upscaler
`default_nettype none

package biu_pkg;

   // storage and ratio limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RATIO  = 8;

   // fixed field widths
   localparam int CH_W          = 8;
   localparam int LOAD_COORD_W  = 8;
   localparam int OUT_COORD_W   = 11;
   localparam int RATIO_FIELD_W = 4;
   localparam int SIZE_FIELD_W  = 9;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 9;
   localparam int PIX_W         = 3 * CH_W;

   // derived widths
   localparam int RATIO_W = $clog2(MAX_RATIO + 1);
   localparam int FRAC_W  = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
   localparam int SQ_W    = $clog2(MAX_RATIO * MAX_RATIO + 1);
   localparam int WP_W    = 2 * RATIO_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int NUM_W   = CH_W + SQ_W;

   // restoring divider
   localparam int DIVD_W        = (NUM_W > OUT_COORD_W) ? NUM_W : OUT_COORD_W;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = (DIVD_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_PAD_W     = DIV_CYCLES * DIV_STEP_BITS;

   // neighbour sequencing
   localparam int NEIGHBOURS = 4;
   localparam int NB_W       = 2;
   localparam int LANES      = 3;
   localparam int CNT_MAX    = (DIV_CYCLES > NEIGHBOURS - 1) ? DIV_CYCLES : NEIGHBOURS - 1;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);

   // reset values, saturated to the limits
   localparam int RESET_RATIO  = (MAX_RATIO < 2) ? MAX_RATIO : 2;
   localparam int RESET_WIDTH  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int RESET_HEIGHT = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_RATIO   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CH_W-1:0] CH_MAX  = 8'd255;
   localparam logic [CH_W-1:0] CH_ZERO = 8'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_SETUP,
      ST_READ,
      ST_LAST,
      ST_CHAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic            load_we;
      logic            sample_start;
      logic            div_start_chan;
      logic            div_step;
      logic            setup;
      logic            rd_issue;
      logic [NB_W-1:0] rd_sel;
      logic            acc_en;
      logic [NB_W-1:0] acc_sel;
      logic            result_load;
   } cmd_type;

   typedef struct packed {
      logic out_of_range;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/biu_req_if.sv
// request channel: pixel loads and sample requests
`default_nettype none

interface biu_req_if;
   import biu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [LOAD_COORD_W-1:0] load_x;
   logic [LOAD_COORD_W-1:0] load_y;
   logic [CH_W-1:0]         load_red;
   logic [CH_W-1:0]         load_green;
   logic [CH_W-1:0]         load_blue;
   logic [OUT_COORD_W-1:0]  out_x;
   logic [OUT_COORD_W-1:0]  out_y;

   modport source (
      output valid, cmd, load_x, load_y, load_red, load_green, load_blue, out_x, out_y,
      input  ready
   );
   modport sink (
      input  valid, cmd, load_x, load_y, load_red, load_green, load_blue, out_x, out_y,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/biu_rsp_if.sv
// response channel: one interpolated pixel per sample
`default_nettype none

interface biu_rsp_if;
   import biu_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic            out_of_range;

   modport source (
      output valid, red, green, blue, out_of_range,
      input  ready
   );
   modport sink (
      input  valid, red, green, blue, out_of_range,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/biu_csr_if.sv
// configuration write channel
`default_nettype none

interface biu_csr_if;
   import biu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );
   modport sink (
      input  valid, index, wdata,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/biu_div.sv
// restoring divider, several quotient bits per cycle while step is high
`default_nettype none

module biu_div (
   input  wire logic                          clock,
   input  wire logic                          start,
   input  wire logic                          step,
   input  wire logic [biu_pkg::DIVD_W-1:0]    dividend,
   input  wire logic [biu_pkg::SQ_W-1:0]      divisor,
   output logic      [biu_pkg::DIV_PAD_W-1:0] quotient,
   output logic      [biu_pkg::SQ_W-1:0]      remainder
);
   import biu_pkg::*;

   logic [SQ_W-1:0]      divisor_ff;
   logic [SQ_W-1:0]      rem_ff;
   logic [SQ_W-1:0]      rem_in;
   logic [DIV_PAD_W-1:0] quo_ff;
   logic [DIV_PAD_W-1:0] quo_in;

   // dividend bits shift out of the top of quo while quotient bits enter below
   always_comb begin
      logic [SQ_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         trial  = {rem_in, quo_in[DIV_PAD_W-1]};
         quo_in = {quo_in[DIV_PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial     = trial - {1'b0, divisor_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= DIV_PAD_W'(dividend);
      end else if (step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/core/biu_dpath.sv
// datapath: config registers, image store, weights, accumulators, dividers
`default_nettype none

module biu_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire biu_pkg::cmd_type                 cmd,
   output biu_pkg::status_type                   status,
   input  wire logic                             csr_we,
   input  wire logic [biu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [biu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [biu_pkg::LOAD_COORD_W-1:0] load_x,
   input  wire logic [biu_pkg::LOAD_COORD_W-1:0] load_y,
   input  wire logic [biu_pkg::CH_W-1:0]         load_red,
   input  wire logic [biu_pkg::CH_W-1:0]         load_green,
   input  wire logic [biu_pkg::CH_W-1:0]         load_blue,
   input  wire logic [biu_pkg::OUT_COORD_W-1:0]  out_x,
   input  wire logic [biu_pkg::OUT_COORD_W-1:0]  out_y,
   output logic      [biu_pkg::CH_W-1:0]         red,
   output logic      [biu_pkg::CH_W-1:0]         green,
   output logic      [biu_pkg::CH_W-1:0]         blue,
   output logic                                  out_of_range
);
   import biu_pkg::*;

   localparam int LIM_W = WID_W + RATIO_W;
   localparam int LIMH_W = HGT_W + RATIO_W;

   // configuration, saturated on write
   logic [RATIO_W-1:0]       ratio_ff;
   logic [SQ_W-1:0]          ratio_sq_ff;
   logic [WID_W-1:0]         width_ff;
   logic [HGT_W-1:0]         height_ff;
   logic [RATIO_FIELD_W-1:0] ratio_field;
   logic [SIZE_FIELD_W-1:0]  size_field;
   logic [RATIO_W-1:0]       ratio_cl;
   logic [WP_W-1:0]          ratio_sq_wide;
   logic [WID_W-1:0]         width_cl;
   logic [HGT_W-1:0]         height_cl;

   assign ratio_field = csr_wdata[RATIO_FIELD_W-1:0];
   assign size_field  = csr_wdata[SIZE_FIELD_W-1:0];

   always_comb begin
      if (ratio_field == '0) begin
         ratio_cl = RATIO_W'(1);
      end else if (32'(ratio_field) > MAX_RATIO) begin
         ratio_cl = RATIO_W'(MAX_RATIO);
      end else begin
         ratio_cl = RATIO_W'(ratio_field);
      end
      if (size_field == '0) begin
         width_cl  = WID_W'(1);
         height_cl = HGT_W'(1);
      end else begin
         width_cl  = (32'(size_field) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(size_field);
         height_cl = (32'(size_field) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(size_field);
      end
   end

   assign ratio_sq_wide = WP_W'(ratio_cl) * WP_W'(ratio_cl);

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff    <= RATIO_W'(RESET_RATIO);
         ratio_sq_ff <= SQ_W'(RESET_RATIO * RESET_RATIO);
         width_ff    <= WID_W'(RESET_WIDTH);
         height_ff   <= HGT_W'(RESET_HEIGHT);
      end else if (csr_we) begin
         case (csr_index)
            REG_SCALE_RATIO: begin
               ratio_ff    <= ratio_cl;
               ratio_sq_ff <= ratio_sq_wide[SQ_W-1:0];
            end
            REG_SOURCE_WIDTH:  width_ff  <= width_cl;
            REG_SOURCE_HEIGHT: height_ff <= height_cl;
            default: ;
         endcase
      end
   end

   // sample coordinate
   logic [OUT_COORD_W-1:0] ox_ff;
   logic [OUT_COORD_W-1:0] oy_ff;

   always_ff @(posedge clock) begin
      if (cmd.sample_start) begin
         ox_ff <= out_x;
         oy_ff <= out_y;
      end
   end

   // accumulators and divider lanes (red, green, blue; lanes 0 and 1 also do x and y)
   logic [NUM_W-1:0]     acc_ff   [LANES];
   logic [DIV_PAD_W-1:0] lane_quo [LANES];
   logic [SQ_W-1:0]      lane_rem [LANES];
   logic [DIVD_W-1:0]    lane_dividend [LANES];
   logic [SQ_W-1:0]      lane_divisor;
   logic                 lane_start;

   assign lane_start   = cmd.sample_start | cmd.div_start_chan;
   assign lane_divisor = cmd.sample_start ? SQ_W'(ratio_ff) : ratio_sq_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_dividend[l] = DIVD_W'(acc_ff[l]);
      end
      if (cmd.sample_start) begin
         lane_dividend[0] = DIVD_W'(out_x);
         lane_dividend[1] = DIVD_W'(out_y);
         lane_dividend[2] = '0;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      biu_div u_div (
         .clock     (clock),
         .start     (lane_start),
         .step      (cmd.div_step),
         .dividend  (lane_dividend[l]),
         .divisor   (lane_divisor),
         .quotient  (lane_quo[l]),
         .remainder (lane_rem[l])
      );
   end

   // range check, neighbour coordinates and weights
   logic [LIM_W-1:0]   limit_x;
   logic [LIMH_W-1:0]  limit_y;
   logic               oor_in;
   logic [COL_W-1:0]   x0_in;
   logic [COL_W-1:0]   x1_in;
   logic [ROW_W-1:0]   y0_in;
   logic [ROW_W-1:0]   y1_in;
   logic [WID_W-1:0]   x0_next;
   logic [WID_W-1:0]   width_m1;
   logic [HGT_W-1:0]   y0_next;
   logic [HGT_W-1:0]   height_m1;
   logic [RATIO_W-1:0] fx;
   logic [RATIO_W-1:0] fy;
   logic [RATIO_W-1:0] rfx;
   logic [RATIO_W-1:0] rfy;
   logic [WP_W-1:0]    wprod [NEIGHBOURS];

   assign limit_x = LIM_W'(width_ff) * LIM_W'(ratio_ff);
   assign limit_y = LIMH_W'(height_ff) * LIMH_W'(ratio_ff);
   assign oor_in  = (32'(ox_ff) >= 32'(limit_x)) || (32'(oy_ff) >= 32'(limit_y));

   assign x0_in     = lane_quo[0][COL_W-1:0];
   assign y0_in     = lane_quo[1][ROW_W-1:0];
   assign x0_next   = WID_W'(x0_in) + WID_W'(1);
   assign y0_next   = HGT_W'(y0_in) + HGT_W'(1);
   assign width_m1  = width_ff - WID_W'(1);
   assign height_m1 = height_ff - HGT_W'(1);
   assign x1_in     = (x0_next < width_ff) ? x0_next[COL_W-1:0] : width_m1[COL_W-1:0];
   assign y1_in     = (y0_next < height_ff) ? y0_next[ROW_W-1:0] : height_m1[ROW_W-1:0];

   assign fx  = RATIO_W'(lane_rem[0][FRAC_W-1:0]);
   assign fy  = RATIO_W'(lane_rem[1][FRAC_W-1:0]);
   assign rfx = ratio_ff - fx;
   assign rfy = ratio_ff - fy;

   // weight order follows the neighbour order: top left, top right, bottom left, bottom right
   assign wprod[0] = WP_W'(rfx) * WP_W'(rfy);
   assign wprod[1] = WP_W'(fx) * WP_W'(rfy);
   assign wprod[2] = WP_W'(rfx) * WP_W'(fy);
   assign wprod[3] = WP_W'(fx) * WP_W'(fy);

   assign status.out_of_range = oor_in;

   logic [COL_W-1:0] x0_ff;
   logic [COL_W-1:0] x1_ff;
   logic [ROW_W-1:0] y0_ff;
   logic [ROW_W-1:0] y1_ff;
   logic [SQ_W-1:0]  weight_ff [NEIGHBOURS];
   logic             oor_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x0_ff  <= x0_in;
         x1_ff  <= x1_in;
         y0_ff  <= y0_in;
         y1_ff  <= y1_in;
         oor_ff <= oor_in;
         for (int n = 0; n < NEIGHBOURS; n++) begin
            weight_ff[n] <= wprod[n][SQ_W-1:0];
         end
      end
   end

   // image store, single port
   logic [PIX_W-1:0]  image_mem [DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] load_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] mem_addr;
   logic [COL_W-1:0]  rd_x;
   logic [ROW_W-1:0]  rd_y;
   logic              load_ok;

   assign load_ok   = (32'(load_x) < MAX_WIDTH) && (32'(load_y) < MAX_HEIGHT);
   assign load_addr = ADDR_W'(load_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(load_x);
   assign rd_x      = cmd.rd_sel[0] ? x1_ff : x0_ff;
   assign rd_y      = cmd.rd_sel[1] ? y1_ff : y0_ff;
   assign rd_addr   = ADDR_W'(rd_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_x);
   assign mem_addr  = cmd.load_we ? load_addr : rd_addr;

   always_ff @(posedge clock) begin
      if (cmd.load_we && load_ok) begin
         image_mem[mem_addr] <= {load_red, load_green, load_blue};
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= image_mem[mem_addr];
      end
   end

   // weighted sum, one neighbour per cycle
   logic [NUM_W-1:0] acc_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         acc_in[l] = acc_ff[l] +
                     NUM_W'(rd_data_ff[PIX_W-1-l*CH_W -: CH_W]) *
                     NUM_W'(weight_ff[cmd.acc_sel]);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (cmd.setup) begin
            acc_ff[l] <= '0;
         end else if (cmd.acc_en) begin
            acc_ff[l] <= acc_in[l];
         end
      end
   end

   // result register
   logic [CH_W-1:0] chan_in [LANES];
   logic [CH_W-1:0] red_ff;
   logic [CH_W-1:0] green_ff;
   logic [CH_W-1:0] blue_ff;
   logic            oor_out_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (oor_ff) begin
            chan_in[l] = CH_ZERO;
         end else if (lane_quo[l] > DIV_PAD_W'(CH_MAX)) begin
            chan_in[l] = CH_MAX;
         end else begin
            chan_in[l] = lane_quo[l][CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         red_ff     <= chan_in[0];
         green_ff   <= chan_in[1];
         blue_ff    <= chan_in[2];
         oor_out_ff <= oor_ff;
      end
   end

   assign red          = red_ff;
   assign green        = green_ff;
   assign blue         = blue_ff;
   assign out_of_range = oor_out_ff;

endmodule

`default_nettype wire

>>> rtl/core/biu_ctrl.sv
// controller: sequences division, neighbour reads and result hand-off
`default_nettype none

module biu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_cmd,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire biu_pkg::status_type status,
   output biu_pkg::cmd_type         cmd
);
   import biu_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && req_cmd == CMD_SAMPLE) begin
               state_in = ST_COORD;
            end
         end
         ST_COORD: begin
            if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_SETUP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SETUP: begin
            cnt_in   = '0;
            state_in = status.out_of_range ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            if (cnt_ff == CNT_W'(NEIGHBOURS - 1)) begin
               state_in = ST_LAST;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_CHAN;
            cnt_in   = '0;
         end
         ST_CHAN: begin
            if (cnt_ff == CNT_W'(DIV_CYCLES)) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.load_we      = req_valid && req_cmd == CMD_LOAD;
            cmd.sample_start = req_valid && req_cmd == CMD_SAMPLE;
         end
         ST_COORD: cmd.div_step = 1'b1;
         ST_SETUP: cmd.setup = 1'b1;
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = cnt_ff[NB_W-1:0];
            cmd.acc_en   = cnt_ff != '0;
            cmd.acc_sel  = cnt_ff[NB_W-1:0] - NB_W'(1);
         end
         ST_LAST: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = NB_W'(NEIGHBOURS - 1);
         end
         ST_CHAN: begin
            cmd.div_start_chan = cnt_ff == '0;
            cmd.div_step       = cnt_ff != '0;
         end
         ST_DONE: cmd.result_load = slot_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.result_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/bilinear_integer_upscaler.sv
// top level of the bilinear integer upscaler
`default_nettype none

// bilinear upscaler holding a MAX_WIDTH x MAX_HEIGHT rgb source image in a
// single-port on-chip store. a load transfer (cmd 0) writes one pixel, so loads
// stream at one per clock while the block is idle. a sample transfer (cmd 1) names
// one output coordinate; the block divides it by the scale ratio, reads the four
// neighbours (right and bottom neighbours clamped to the image edge), forms the
// weighted sum per channel and divides by ratio squared. a sample occupies the
// block through accept, coordinate division, setup, four reads, a final
// accumulate, channel division and hand-off; its length is set by the shared
// restoring dividers (4 quotient bits a cycle) and the one read a cycle of the
// image store. a coordinate beyond the scaled image skips the reads and the
// channel division and returns zeros with out_of_range. the result sits in
// an output register, so the next transfer is taken while it waits.
// configuration values saturate on write (ratio 1..MAX_RATIO, sizes
// 1..MAX_WIDTH/MAX_HEIGHT); a pixel must be loaded before it is sampled.

module bilinear_integer_upscaler (
   input wire logic  clock,
   input wire logic  reset,
   biu_req_if.sink   req_bus,
   biu_rsp_if.source rsp_bus,
   biu_csr_if.sink   csr_bus
);
   import biu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // configuration writes are always taken
   assign csr_bus.ready = 1'b1;

   // control: state machine, counter and response valid
   biu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // data: registers, image store, arithmetic and result register
   biu_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_wdata    (csr_bus.wdata),
      .load_x       (req_bus.load_x),
      .load_y       (req_bus.load_y),
      .load_red     (req_bus.load_red),
      .load_green   (req_bus.load_green),
      .load_blue    (req_bus.load_blue),
      .out_x        (req_bus.out_x),
      .out_y        (req_bus.out_y),
      .red          (rsp_bus.red),
      .green        (rsp_bus.green),
      .blue         (rsp_bus.blue),
      .out_of_range (rsp_bus.out_of_range)
   );

endmodule

`default_nettype wire
